[rtl/core/socks5_connect_client_macros.svh]
// Assertion macros shared by the SOCKS5 connect client RTL.
// Included by every module that carries concurrent assertions.
`ifndef SOCKS5_CONNECT_CLIENT_MACROS_SVH
`define SOCKS5_CONNECT_CLIENT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define S5CC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define S5CC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/s5cc_pkg.sv]
// Types and constants for the SOCKS5 connect client.
// No dependencies; imported by the front, queue, back and top modules.
`default_nettype none

package s5cc_pkg;

    // Input item modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_NAME  = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;

    // Protocol constants
    localparam logic [7:0] SOCKS_VER   = 8'd5;
    localparam logic [7:0] NAME_MAX    = 8'd255;
    localparam logic [7:0] ATYP_IPV4   = 8'd1;
    localparam logic [7:0] ATYP_DOMAIN = 8'd3;
    localparam logic [7:0] ATYP_IPV6   = 8'd4;

    // Bound address plus port bytes to skip after the first byte that follows the address type
    localparam logic [8:0] SKIP_IPV4   = 9'd5;
    localparam logic [8:0] SKIP_IPV6   = 9'd17;
    localparam logic [8:0] SKIP_PORT   = 9'd2;

    // Greeting is the first three, connect header the first four
    localparam logic [7:0] HDR_BYTES [4] = '{8'd5, 8'd1, 8'd0, 8'd3};

    // Status reported with every result
    typedef enum logic [2:0] {
        ST_BUSY       = 3'd0,
        ST_CONNECTED  = 3'd1,
        ST_NAME_LONG  = 3'd2,
        ST_GREET_BAD  = 3'd3,
        ST_REPLY_BAD  = 3'd4,
        ST_REFUSED    = 3'd5,
        ST_BAD_ATYP   = 3'd6,
        ST_UNEXPECTED = 3'd7
    } t_status;

    // Shape of the result burst caused by one input item
    typedef enum logic [1:0] {
        RUN_STATUS = 2'd0,  // one status-only result
        RUN_GREET  = 2'd1,  // greeting bytes
        RUN_HEADER = 2'd2,  // connect header and name length, optionally port bytes
        RUN_NAME   = 2'd3   // one hostname byte, optionally port bytes
    } t_run_kind;

    // Work descriptor passed from the front to the back
    typedef struct packed {
        t_run_kind   kind;
        t_status     status;
        logic [7:0]  code;
        logic [7:0]  data;
        logic        with_port;
        logic [15:0] port;
    } t_run;

endpackage

`default_nettype wire

[rtl/core/s5cc_front.sv]
// Front part: handshake state machine that classifies each input item
// and emits one run descriptor per accepted item. Uses s5cc_pkg.
`default_nettype none
`include "socks5_connect_client_macros.svh"

module s5cc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [1:0]    i_mode,
    input  wire logic [7:0]    i_name_length,
    input  wire logic [15:0]   i_dest_port,
    input  wire logic [7:0]    i_data_byte,
    output s5cc_pkg::t_run     o_run
);
    import s5cc_pkg::*;

    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_GREET = 9'b000000010,
        PH_NAME  = 9'b000000100,
        PH_REPLY = 9'b000001000,
        PH_LAST1 = 9'b000010000,
        PH_LAST3 = 9'b000100000,
        PH_LAST4 = 9'b001000000,
        PH_LASTX = 9'b010000000,
        PH_SKIP  = 9'b100000000
    } t_phase;

    t_phase      r_phase,       n_phase;
    logic [7:0]  r_byte_count,  n_byte_count;
    logic [7:0]  r_host_length, n_host_length;
    logic [15:0] r_target_port, n_target_port;
    logic [7:0]  r_reply_code,  n_reply_code;
    logic        r_reply_ok,    n_reply_ok;
    logic [8:0]  r_skip_count,  n_skip_count;

    logic [7:0]  count_inc;
    logic [8:0]  skip_dec;
    t_run        run;

    assign count_inc = r_byte_count + 8'd1;
    assign skip_dec  = r_skip_count - 9'd1;

    // Advance the handshake and describe the results of this item
    always_comb begin
        n_phase       = r_phase;
        n_byte_count  = r_byte_count;
        n_host_length = r_host_length;
        n_target_port = r_target_port;
        n_reply_code  = r_reply_code;
        n_reply_ok    = r_reply_ok;
        n_skip_count  = r_skip_count;

        run.kind      = RUN_STATUS;
        run.status    = ST_BUSY;
        run.code      = 8'd0;
        run.data      = 8'd0;
        run.with_port = 1'b0;
        run.port      = r_target_port;

        if (i_accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_mode != MODE_START) begin
                        run.status = ST_UNEXPECTED;
                    end else if (i_name_length == NAME_MAX) begin
                        run.status = ST_NAME_LONG;
                    end else begin
                        n_host_length = i_name_length;
                        n_target_port = i_dest_port;
                        n_byte_count  = 8'd0;
                        n_reply_ok    = 1'b1;
                        run.kind      = RUN_GREET;
                        n_phase       = PH_GREET;
                    end
                end
                PH_GREET: begin
                    if (i_mode != MODE_RX) begin
                        run.status = ST_UNEXPECTED;
                    end else if (r_byte_count == 8'd0) begin
                        if (i_data_byte != SOCKS_VER) n_reply_ok = 1'b0;
                        n_byte_count = 8'd1;
                    end else begin
                        n_byte_count = 8'd0;
                        if (!r_reply_ok || i_data_byte != 8'd0) begin
                            n_reply_ok = 1'b0;
                            run.status = ST_GREET_BAD;
                            n_phase    = PH_IDLE;
                        end else begin
                            run.kind = RUN_HEADER;
                            run.data = r_host_length;
                            if (r_host_length == 8'd0) begin
                                run.with_port = 1'b1;
                                n_reply_ok    = 1'b1;
                                n_phase       = PH_REPLY;
                            end else begin
                                n_phase = PH_NAME;
                            end
                        end
                    end
                end
                PH_NAME: begin
                    if (i_mode != MODE_NAME) begin
                        run.status = ST_UNEXPECTED;
                    end else begin
                        run.kind = RUN_NAME;
                        run.data = i_data_byte;
                        if (count_inc >= r_host_length) begin
                            // last name byte: append the port and await the reply
                            run.with_port = 1'b1;
                            n_byte_count  = 8'd0;
                            n_reply_ok    = 1'b1;
                            n_phase       = PH_REPLY;
                        end else begin
                            n_byte_count = count_inc;
                        end
                    end
                end
                PH_REPLY: begin
                    if (i_mode != MODE_RX) begin
                        run.status = ST_UNEXPECTED;
                    end else begin
                        priority case (r_byte_count)
                            8'd0: begin
                                if (i_data_byte != SOCKS_VER) n_reply_ok = 1'b0;
                                n_byte_count = 8'd1;
                            end
                            8'd1: begin
                                n_reply_code = i_data_byte;
                                n_byte_count = 8'd2;
                            end
                            8'd2: begin
                                if (i_data_byte != 8'd0) n_reply_ok = 1'b0;
                                n_byte_count = 8'd3;
                            end
                            default: begin
                                n_byte_count = 8'd0;
                                priority if (i_data_byte == ATYP_IPV4)   n_phase = PH_LAST1;
                                else if     (i_data_byte == ATYP_DOMAIN) n_phase = PH_LAST3;
                                else if     (i_data_byte == ATYP_IPV6)   n_phase = PH_LAST4;
                                else                                     n_phase = PH_LASTX;
                            end
                        endcase
                    end
                end
                PH_LAST1, PH_LAST3, PH_LAST4, PH_LASTX: begin
                    // protocol check wins over refusal, refusal over address type
                    priority if (i_mode != MODE_RX) begin
                        run.status = ST_UNEXPECTED;
                    end else if (!r_reply_ok) begin
                        run.status = ST_REPLY_BAD;
                        n_phase    = PH_IDLE;
                    end else if (r_reply_code != 8'd0) begin
                        run.status = ST_REFUSED;
                        run.code   = r_reply_code;
                        n_phase    = PH_IDLE;
                    end else if (r_phase == PH_LASTX) begin
                        run.status = ST_BAD_ATYP;
                        n_phase    = PH_IDLE;
                    end else begin
                        priority if (r_phase == PH_LAST1) n_skip_count = SKIP_IPV4;
                        else if (r_phase == PH_LAST3)
                            n_skip_count = {1'b0, i_data_byte} + SKIP_PORT;
                        else                              n_skip_count = SKIP_IPV6;
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (i_mode != MODE_RX) begin
                        run.status = ST_UNEXPECTED;
                    end else begin
                        n_skip_count = skip_dec;
                        if (skip_dec == 9'd0) begin
                            run.status = ST_CONNECTED;
                            n_phase    = PH_IDLE;
                        end
                    end
                end
                default: begin
                    run.status = ST_UNEXPECTED;
                end
            endcase
        end
    end

    assign o_run = run;

    // Hold handshake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_byte_count  <= 8'd0;
            r_host_length <= 8'd0;
            r_target_port <= 16'd0;
            r_reply_code  <= 8'd0;
            r_reply_ok    <= 1'b1;
            r_skip_count  <= 9'd0;
        end else begin
            r_phase       <= n_phase;
            r_byte_count  <= n_byte_count;
            r_host_length <= n_host_length;
            r_target_port <= n_target_port;
            r_reply_code  <= n_reply_code;
            r_reply_ok    <= n_reply_ok;
            r_skip_count  <= n_skip_count;
        end
    end

    `S5CC_ASSERT_NEXT(a_unexpected_keeps_state, i_clk, i_rst_n, i_accept && (run.status == ST_UNEXPECTED), $stable(r_phase) && $stable(r_byte_count) && $stable(r_skip_count), "out-of-phase item changed handshake state")

endmodule

`default_nettype wire

[rtl/core/s5cc_queue.sv]
// Short descriptor queue between the front and the back.
// Flip-flop storage with a registered count; uses s5cc_pkg::t_run.
`default_nettype none
`include "socks5_connect_client_macros.svh"

module s5cc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire s5cc_pkg::t_run i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output s5cc_pkg::t_run      o_data,
    output logic                o_empty
);
    import s5cc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_run             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store descriptors
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `S5CC_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full, "descriptor pushed into a full queue")
    `S5CC_ASSERT_NOW(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, !o_empty, "descriptor popped from an empty queue")

endmodule

`default_nettype wire

[rtl/core/s5cc_back.sv]
// Back part: expands each run descriptor into result items, one per pop.
// Holds the current run in an output register; uses s5cc_pkg.
`default_nettype none
`include "socks5_connect_client_macros.svh"

module s5cc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire s5cc_pkg::t_run i_run,
    input  wire logic          i_run_empty,
    output logic               o_run_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic               o_tx_valid,
    output logic [7:0]         o_tx_byte,
    output logic [2:0]         o_status,
    output logic [7:0]         o_server_code,
    output logic               o_last_of_run
);
    import s5cc_pkg::*;

    logic       r_valid;
    t_run       r_run;
    logic [2:0] r_idx;
    logic [2:0] run_len;
    logic       last;
    logic       take;
    logic       load;

    // Number of results in the current run
    always_comb begin
        unique case (r_run.kind)
            RUN_STATUS: run_len = 3'd1;
            RUN_GREET:  run_len = 3'd3;
            RUN_HEADER: run_len = r_run.with_port ? 3'd7 : 3'd5;
            RUN_NAME:   run_len = r_run.with_port ? 3'd3 : 3'd1;
            default:    run_len = 3'd1;
        endcase
    end

    assign last      = (r_idx == run_len - 3'd1);
    assign take      = i_pop && r_valid;
    assign load      = !i_run_empty && (!r_valid || (take && last));
    assign o_run_pop = load;

    // Select the byte at the current position of the run
    always_comb begin
        o_tx_byte = 8'd0;
        unique case (r_run.kind)
            RUN_STATUS: o_tx_byte = 8'd0;
            RUN_GREET:  o_tx_byte = HDR_BYTES[r_idx[1:0]];
            RUN_HEADER: begin
                priority if (r_idx < 3'd4)  o_tx_byte = HDR_BYTES[r_idx[1:0]];
                else if (r_idx == 3'd4)     o_tx_byte = r_run.data;
                else if (r_idx == 3'd5)     o_tx_byte = r_run.port[15:8];
                else                        o_tx_byte = r_run.port[7:0];
            end
            RUN_NAME: begin
                priority if (r_idx == 3'd0) o_tx_byte = r_run.data;
                else if (r_idx == 3'd1)     o_tx_byte = r_run.port[15:8];
                else                        o_tx_byte = r_run.port[7:0];
            end
            default: o_tx_byte = 8'd0;
        endcase
    end

    assign o_empty       = !r_valid;
    assign o_tx_valid    = (r_run.kind != RUN_STATUS);
    assign o_status      = (r_run.kind == RUN_STATUS) ? r_run.status : ST_BUSY;
    assign o_server_code = (r_run.kind == RUN_STATUS) ? r_run.code : 8'd0;
    assign o_last_of_run = last;

    // Advance through the run; load the next one as the last result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= 3'd0;
        end else if (take && last) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (take) begin
            r_idx   <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_run <= i_run;
        end
    end

    `S5CC_ASSERT_NOW(a_idx_in_run, i_clk, i_rst_n, r_valid, r_idx < run_len, "result index ran past the end of its run")
    `S5CC_ASSERT_NOW(a_status_only_last, i_clk, i_rst_n, r_valid && (o_status != ST_BUSY), o_last_of_run && !o_tx_valid, "final status shown on a result that is not the last of its run")

endmodule

`default_nettype wire

[rtl/core/socks5_connect_client.sv]
// SOCKS5 connect client top level: front state machine, descriptor queue
// and result expander. Depends on s5cc_pkg, s5cc_front, s5cc_queue, s5cc_back.
`default_nettype none

// Client side of a SOCKS5 CONNECT handshake to a domain-name target. One input
// item is accepted per clock while the descriptor queue has room (full low);
// the front state machine classifies it in that same cycle and queues one
// descriptor. Each item yields 1 to 7 result items: 3 for the greeting, 5 for
// the connect header (7 when the name is empty and the port follows), 1 or 3
// for a hostname byte, 1 for everything else. The back part delivers one
// result per clock on pop, so sustained throughput is one result per cycle;
// the queue (QUEUE_DEPTH descriptors) absorbs bursts. When the back part is
// idle, the first result of an item is registered in the queue and then in
// the back part's run register before it becomes visible.
module socks5_connect_client #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [1:0]    i_mode,
    input  wire logic [7:0]    i_name_length,
    input  wire logic [15:0]   i_dest_port,
    input  wire logic [7:0]    i_data_byte,
    output logic               empty,
    input  wire logic          pop,
    output logic               o_tx_valid,
    output logic [7:0]         o_tx_byte,
    output logic [2:0]         o_status,
    output logic [7:0]         o_server_code,
    output logic               o_last_of_run
);
    import s5cc_pkg::*;

    logic  accept;
    t_run  front_run;
    t_run  queue_run;
    logic  queue_full;
    logic  queue_empty;
    logic  queue_pop;

    assign accept = push && !queue_full;
    assign full   = queue_full;

    s5cc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_mode        (i_mode),
        .i_name_length (i_name_length),
        .i_dest_port   (i_dest_port),
        .i_data_byte   (i_data_byte),
        .o_run         (front_run)
    );

    s5cc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_run),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_data  (queue_run),
        .o_empty (queue_empty)
    );

    s5cc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_run         (queue_run),
        .i_run_empty   (queue_empty),
        .o_run_pop     (queue_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_status      (o_status),
        .o_server_code (o_server_code),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

[tb/sv/s5cc_tb_pkg.sv]
// Handshake tracker for the SOCKS5 connect client testbench: predicts the
// results of every accepted request and checks the ones the block delivers.
// Depends on s5cc_pkg for modes, protocol constants and status codes.
package s5cc_tb_pkg;
    import s5cc_pkg::*;

    // Where the client stands in the handshake
    typedef enum logic [3:0] {
        HS_IDLE,
        HS_GREET,
        HS_NAME,
        HS_REPLY,
        HS_ATYP_V4,
        HS_ATYP_NAME,
        HS_ATYP_V6,
        HS_ATYP_BAD,
        HS_SKIP
    } hs_phase_t;

    typedef struct {
        logic       tx_valid;
        logic [7:0] tx_byte;
        t_status    status;
        logic [7:0] code;
        logic       last;
    } hs_result_t;

    class hs_tracker;
        hs_phase_t   phase = HS_IDLE;
        logic [7:0]  byte_count = 8'd0;
        logic [7:0]  host_length = 8'd0;
        logic [15:0] target_port = 16'd0;
        logic [7:0]  reply_code = 8'd0;
        logic        reply_ok = 1'b1;
        logic [8:0]  skip_count = 9'd0;

        hs_result_t  awaited[$];
        hs_result_t  burst[$];

        int errors;
        int checked;
        int requests;
        int connected;
        int refused;
        int failed;

        function int pending();
            return awaited.size();
        endfunction

        // Append one result to the burst of the current request
        function void add(logic v, logic [7:0] b, t_status st, logic [7:0] code);
            hs_result_t r;
            r.tx_valid = v;
            r.tx_byte  = v ? b : 8'd0;
            r.status   = st;
            r.code     = code;
            r.last     = 1'b0;
            burst.push_back(r);
        endfunction

        // Send the port bytes and wait for the connect reply
        function void add_port();
            add(1'b1, target_port[15:8], ST_BUSY, 8'd0);
            add(1'b1, target_port[7:0], ST_BUSY, 8'd0);
            byte_count = 8'd0;
            reply_ok   = 1'b1;
            phase      = HS_REPLY;
        endfunction

        // Predict the results of one accepted request and queue them
        function void note_request(logic [1:0] mode, logic [7:0] len,
                                   logic [15:0] port, logic [7:0] d);
            hs_result_t r;
            burst.delete();
            requests++;
            case (phase)
                HS_IDLE: begin
                    if (mode != MODE_START) begin
                        add(1'b0, 8'd0, ST_UNEXPECTED, 8'd0);
                    end else if (len >= NAME_MAX) begin
                        add(1'b0, 8'd0, ST_NAME_LONG, 8'd0);
                        failed++;
                    end else begin
                        host_length = len;
                        target_port = port;
                        byte_count  = 8'd0;
                        reply_ok    = 1'b1;
                        for (int i = 0; i < 3; i++) add(1'b1, HDR_BYTES[i], ST_BUSY, 8'd0);
                        phase = HS_GREET;
                    end
                end
                HS_GREET: begin
                    if (mode != MODE_RX) begin
                        add(1'b0, 8'd0, ST_UNEXPECTED, 8'd0);
                    end else if (byte_count == 8'd0) begin
                        if (d != SOCKS_VER) reply_ok = 1'b0;
                        byte_count = 8'd1;
                        add(1'b0, 8'd0, ST_BUSY, 8'd0);
                    end else begin
                        if (d != 8'd0) reply_ok = 1'b0;
                        byte_count = 8'd0;
                        if (!reply_ok) begin
                            add(1'b0, 8'd0, ST_GREET_BAD, 8'd0);
                            phase = HS_IDLE;
                            failed++;
                        end else begin
                            for (int i = 0; i < 4; i++) add(1'b1, HDR_BYTES[i], ST_BUSY, 8'd0);
                            add(1'b1, host_length, ST_BUSY, 8'd0);
                            if (host_length == 8'd0) add_port();
                            else phase = HS_NAME;
                        end
                    end
                end
                HS_NAME: begin
                    if (mode != MODE_NAME) begin
                        add(1'b0, 8'd0, ST_UNEXPECTED, 8'd0);
                    end else begin
                        add(1'b1, d, ST_BUSY, 8'd0);
                        byte_count = byte_count + 8'd1;
                        if (byte_count >= host_length) add_port();
                    end
                end
                HS_REPLY: begin
                    if (mode != MODE_RX) begin
                        add(1'b0, 8'd0, ST_UNEXPECTED, 8'd0);
                    end else begin
                        case (byte_count)
                            8'd0: begin
                                if (d != SOCKS_VER) reply_ok = 1'b0;
                                byte_count = 8'd1;
                            end
                            8'd1: begin
                                reply_code = d;
                                byte_count = 8'd2;
                            end
                            8'd2: begin
                                if (d != 8'd0) reply_ok = 1'b0;
                                byte_count = 8'd3;
                            end
                            default: begin
                                byte_count = 8'd0;
                                if (d == ATYP_IPV4) phase = HS_ATYP_V4;
                                else if (d == ATYP_DOMAIN) phase = HS_ATYP_NAME;
                                else if (d == ATYP_IPV6) phase = HS_ATYP_V6;
                                else phase = HS_ATYP_BAD;
                            end
                        endcase
                        add(1'b0, 8'd0, ST_BUSY, 8'd0);
                    end
                end
                HS_ATYP_V4, HS_ATYP_NAME, HS_ATYP_V6, HS_ATYP_BAD: begin
                    // protocol error beats refusal, refusal beats a bad address type
                    if (mode != MODE_RX) begin
                        add(1'b0, 8'd0, ST_UNEXPECTED, 8'd0);
                    end else if (!reply_ok) begin
                        add(1'b0, 8'd0, ST_REPLY_BAD, 8'd0);
                        phase = HS_IDLE;
                        failed++;
                    end else if (reply_code != 8'd0) begin
                        add(1'b0, 8'd0, ST_REFUSED, reply_code);
                        phase = HS_IDLE;
                        refused++;
                    end else if (phase == HS_ATYP_BAD) begin
                        add(1'b0, 8'd0, ST_BAD_ATYP, 8'd0);
                        phase = HS_IDLE;
                        failed++;
                    end else begin
                        if (phase == HS_ATYP_V4) skip_count = SKIP_IPV4;
                        else if (phase == HS_ATYP_NAME) skip_count = {1'b0, d} + SKIP_PORT;
                        else skip_count = SKIP_IPV6;
                        phase = HS_SKIP;
                        add(1'b0, 8'd0, ST_BUSY, 8'd0);
                    end
                end
                HS_SKIP: begin
                    if (mode != MODE_RX) begin
                        add(1'b0, 8'd0, ST_UNEXPECTED, 8'd0);
                    end else begin
                        skip_count = skip_count - 9'd1;
                        if (skip_count == 9'd0) begin
                            add(1'b0, 8'd0, ST_CONNECTED, 8'd0);
                            phase = HS_IDLE;
                            connected++;
                        end else begin
                            add(1'b0, 8'd0, ST_BUSY, 8'd0);
                        end
                    end
                end
                default: add(1'b0, 8'd0, ST_UNEXPECTED, 8'd0);
            endcase

            // flag the final result of the burst
            foreach (burst[i]) begin
                r = burst[i];
                r.last = (i == burst.size() - 1);
                awaited.push_back(r);
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            // keep the log short on a badly broken run
            if (errors <= 40) $display("mismatch at result %0d: %s", checked, what);
        endtask

        // Compare one delivered result with the oldest prediction
        task check_result(hs_result_t got);
            hs_result_t want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("no result expected, got tx %0d/%0d status %0d",
                                          got.tx_valid, got.tx_byte, got.status));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.tx_valid !== want.tx_valid)
                report_mismatch($sformatf("tx_valid %0d, want %0d", got.tx_valid, want.tx_valid));
            if (got.tx_byte !== want.tx_byte)
                report_mismatch($sformatf("tx_byte %0d, want %0d", got.tx_byte, want.tx_byte));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.code !== want.code)
                report_mismatch($sformatf("server_code %0d, want %0d", got.code, want.code));
            if (got.last !== want.last)
                report_mismatch($sformatf("last_of_run %0d, want %0d", got.last, want.last));
        endtask
    endclass

endpackage

[tb/sv/socks5_connect_client_tb.sv]
// Top-level testbench for socks5_connect_client: directed handshakes, then
// random sessions under several idle and stall patterns.
// Depends on s5cc_pkg, s5cc_tb_pkg and the RTL of the block.
module socks5_connect_client_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import s5cc_pkg::*;
    import s5cc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 30;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [1:0]  i_mode = MODE_START;
    logic [7:0]  i_name_length = 8'd0;
    logic [15:0] i_dest_port = 16'd0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        full;
    logic        empty;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic [2:0]  o_status;
    logic [7:0]  o_server_code;
    logic        o_last_of_run;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    hs_tracker board;

    socks5_connect_client u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_mode        (i_mode),
        .i_name_length (i_name_length),
        .i_dest_port   (i_dest_port),
        .i_data_byte   (i_data_byte),
        .empty         (empty),
        .pop           (pop),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_status      (o_status),
        .o_server_code (o_server_code),
        .o_last_of_run (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result side at random
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        hs_result_t seen;
        if (i_rst_n && pop && !empty) begin
            seen.tx_valid = o_tx_valid;
            seen.tx_byte  = o_tx_byte;
            seen.status   = t_status'(o_status);
            seen.code     = o_server_code;
            seen.last     = o_last_of_run;
            board.check_result(seen);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycles, board.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [7:0] pick(int pct, logic [7:0] usual);
        return ($urandom_range(99) < pct) ? usual : 8'($urandom_range(255));
    endfunction

    // Offer one request, idling first at random; return once it is taken
    task automatic send_request(input logic [1:0] mode, input logic [7:0] len,
                                input logic [15:0] port, input logic [7:0] data);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push          <= 1'b1;
        i_mode        <= mode;
        i_name_length <= len;
        i_dest_port   <= port;
        i_data_byte   <= data;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!full) begin
                board.note_request(mode, len, port, data);
                taken = 1'b1;
            end
            @(negedge i_clk);
        end
    endtask

    // Send one request of a session, now and then preceded by a stray one
    task automatic send_step(input logic [1:0] mode, input logic [7:0] len,
                             input logic [15:0] port, input logic [7:0] data);
        if ($urandom_range(99) < 5)
            send_request(2'($urandom_range(3)),
                         $urandom_range(1) ? NAME_MAX : 8'($urandom_range(3)),
                         16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));
        send_request(mode, len, port, data);
    endtask

    // Hold off the sender until every predicted result has arrived
    task automatic wait_drained();
        push <= 1'b0;
        do @(negedge i_clk); while (board.pending() != 0);
    endtask

    // One handshake with random content, mostly well formed
    task automatic run_session();
        logic [7:0] len;
        logic [7:0] atyp;
        logic [7:0] first;
        int sel;

        if ($urandom_range(29) == 0) len = 8'($urandom_range(24, 5));
        else len = 8'($urandom_range(4));
        send_step(MODE_START, len, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)));

        // greeting reply
        send_step(MODE_RX, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
                  pick(90, SOCKS_VER));
        send_step(MODE_RX, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
                  pick(90, 8'd0));
        if (board.phase == HS_IDLE) return;

        // hostname bytes
        while (board.phase == HS_NAME)
            send_step(MODE_NAME, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
                      8'($urandom_range(255)));

        // connect reply header
        sel = $urandom_range(19);
        if (sel < 6) atyp = ATYP_IPV4;
        else if (sel < 12) atyp = ATYP_DOMAIN;
        else if (sel < 18) atyp = ATYP_IPV6;
        else atyp = 8'($urandom_range(255));
        send_step(MODE_RX, 8'd0, 16'd0, pick(90, SOCKS_VER));
        send_step(MODE_RX, 8'd0, 16'd0, pick(80, 8'd0));
        send_step(MODE_RX, 8'd0, 16'd0, pick(90, 8'd0));
        send_step(MODE_RX, 8'd0, 16'd0, atyp);

        // keep bound-name lengths short apart from the odd long one
        if (atyp == ATYP_DOMAIN && $urandom_range(24) != 0) first = 8'($urandom_range(12));
        else first = 8'($urandom_range(255));
        send_step(MODE_RX, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)), first);

        // skip the bound address, and recover from any stray request
        while (board.phase != HS_IDLE)
            send_request(board.phase == HS_NAME ? MODE_NAME : MODE_RX,
                         8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
                         8'($urandom_range(255)));
    endtask

    initial begin
        int start;
        board = new();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // out-of-phase requests and an overlong name while idle
        send_request(MODE_NAME, 8'd0, 16'd0, 8'hFF);
        send_request(2'd3, 8'hFF, 16'hFFFF, 8'hFF);
        send_request(MODE_START, NAME_MAX, 16'hFFFF, 8'd0);
        // empty name: greeting, early hostname byte, start while busy
        send_request(MODE_START, 8'd0, 16'hFFFF, 8'hFF);
        send_request(MODE_NAME, 8'd0, 16'd0, 8'hAA);
        send_request(MODE_START, 8'd3, 16'd80, 8'd0);
        send_request(MODE_RX, 8'd0, 16'd0, SOCKS_VER);
        send_request(MODE_RX, 8'd0, 16'd0, 8'd0);
        // bad version together with refusal and bad address type
        send_request(MODE_RX, 8'd0, 16'd0, 8'd7);
        send_request(MODE_RX, 8'd0, 16'd0, 8'hFF);
        send_request(MODE_RX, 8'd0, 16'd0, 8'd0);
        send_request(MODE_RX, 8'd0, 16'd0, 8'd9);
        send_request(MODE_RX, 8'd0, 16'd0, 8'd0);
        // longest accepted name, greeting reply rejected
        send_request(MODE_START, 8'd254, 16'd0, 8'd0);
        send_request(MODE_RX, 8'd0, 16'd0, SOCKS_VER);
        send_request(MODE_RX, 8'd0, 16'd0, 8'd1);
        // refusal wins over a bad address type
        send_request(MODE_START, 8'd0, 16'h8001, 8'd0);
        send_request(MODE_RX, 8'd0, 16'd0, SOCKS_VER);
        send_request(MODE_RX, 8'd0, 16'd0, 8'd0);
        send_request(MODE_RX, 8'd0, 16'd0, SOCKS_VER);
        send_request(MODE_RX, 8'd0, 16'd0, 8'h80);
        send_request(MODE_RX, 8'd0, 16'd0, 8'd0);
        send_request(MODE_RX, 8'd0, 16'd0, 8'd2);
        send_request(MODE_RX, 8'd0, 16'd0, 8'd0);
        wait_drained();

        // random sessions, one idle pattern per phase, drained in between
        start = board.requests;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            while (board.requests < start + (ph + 1) * PHASE_ITEMS) run_session();
            wait_drained();
        end

        // let any stray result show up
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (20) @(negedge i_clk);

        $display("covered %0d requests and %0d results over four idle/stall patterns",
                 board.requests, board.checked);
        $display("handshakes: %0d connected, %0d refused, %0d ended in other errors",
                 board.connected, board.refused, board.failed);
        if (board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/s5cc_pkg.sv
rtl/core/s5cc_front.sv
rtl/core/s5cc_queue.sv
rtl/core/s5cc_back.sv
rtl/core/socks5_connect_client.sv
tb/sv/s5cc_tb_pkg.sv
tb/sv/socks5_connect_client_tb.sv
